// ===== rtl/frs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frs_pkg
// Shared constants and the result word type of the frame receiver.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'h3a;

   localparam logic [1:0] STATUS_RECEIVING = 2'd0;
   localparam logic [1:0] STATUS_GOOD      = 2'd1;
   localparam logic [1:0] STATUS_BAD_SUM   = 2'd2;

   typedef struct packed {
      logic [1:0]  status;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [15:0] data_index;
      logic [7:0]  frame_command;
      logic [15:0] frame_length;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/frs_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frs_parse
// Frame state tracker: hunts for sync, collects length and command, tags
// payload words with their index and checks the additive checksum.
// ----------------------------------------------------------------------------
module frs_parse
   import frs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] rx_byte,
   output result_type      result
);

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_LEN_LO = 3'd1,
      PH_LEN_HI = 3'd2,
      PH_CMD    = 3'd3,
      PH_DATA   = 3'd4,
      PH_CHECK  = 3'd5
   } phase_type;

   phase_type   phase_ff,   phase_in;
   logic [15:0] length_ff,  length_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  sum_ff,     sum_in;
   logic [15:0] count_ff,   count_in;

   logic [7:0]  sum_add;
   logic [16:0] count_inc;
   logic [7:0]  expect_sum;

   assign sum_add    = sum_ff + rx_byte;
   assign count_inc  = {1'b0, count_ff} + 17'd1;
   assign expect_sum = (~sum_ff) + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      length_in  = length_ff;
      command_in = command_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      result.status     = STATUS_RECEIVING;
      result.data_valid = 1'b0;
      result.data_byte  = 8'd0;
      result.data_index = 16'd0;

      case (phase_ff)
         PH_LEN_LO: begin
            length_in = {8'd0, rx_byte};
            sum_in    = sum_add;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = {rx_byte, length_ff[7:0]};
            sum_in    = sum_add;
            phase_in  = PH_CMD;
         end
         PH_CMD: begin
            command_in = rx_byte;
            sum_in     = sum_add;
            if (length_ff != 16'd0) begin
               count_in = 16'd0;
               phase_in = PH_DATA;
            end else begin
               phase_in = PH_CHECK;
            end
         end
         PH_DATA: begin
            sum_in            = sum_add;
            result.data_valid = 1'b1;
            result.data_byte  = rx_byte;
            result.data_index = count_ff;
            count_in          = count_inc[15:0];
            if (count_inc >= {1'b0, length_ff}) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            result.status = (expect_sum == rx_byte) ? STATUS_GOOD : STATUS_BAD_SUM;
            phase_in      = PH_HUNT;
         end
         default: begin
            // hunting and unused codes clear the frame registers and look for sync
            length_in  = 16'd0;
            command_in = 8'd0;
            sum_in     = 8'd0;
            phase_in   = (rx_byte == SYNC_BYTE) ? PH_LEN_LO : PH_HUNT;
         end
      endcase

      result.frame_command = command_in;
      result.frame_length  = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         length_ff  <= 16'd0;
         command_ff <= 8'd0;
         sum_ff     <= 8'd0;
         count_ff   <= 16'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         command_ff <= command_in;
         sum_ff     <= sum_in;
         count_ff   <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/frame_receiver_sum_checksum_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// frame_receiver_sum_checksum_core
// Length-prefixed frame receiver with additive checksum, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Each accepted byte produces exactly one result word in the output stage. The
// receiver skips bytes until sync 0x3a, then takes a little-endian 16-bit
// length, a command byte, the payload (handed out with its index) and a
// checksum byte, which reports good or bad and returns to hunting. The frame
// state updates once per accepted byte, so one byte is taken every clock while
// req_stall is low; a two-entry output stage (result register plus skid register)
// lets input keep flowing for one more byte after the result side stalls.
// req_stall is a registered signal.
module frame_receiver_sum_checksum_core
   import frs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic        rsp_data_valid,
   output      logic [7:0]  rsp_data_byte,
   output      logic [15:0] rsp_data_index,
   output      logic [7:0]  rsp_frame_command,
   output      logic [15:0] rsp_frame_length
);

   result_type new_result;
   result_type out_ff;
   result_type skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       req_accept;
   logic       rsp_take;

   assign req_accept = req_valid & ~skid_valid_ff;
   assign rsp_take   = out_valid_ff & ~rsp_stall;

   frs_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .result  (new_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_take) begin
         // drain skid first; no new word arrives while skid is full
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_take) begin
         out_ff <= skid_valid_ff ? skid_ff : new_result;
      end else if (req_accept) begin
         skid_ff <= new_result;
      end
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_data_valid    = out_ff.data_valid;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_data_index    = out_ff.data_index;
   assign rsp_frame_command = out_ff.frame_command;
   assign rsp_frame_length  = out_ff.frame_length;

endmodule
`default_nettype wire

// ===== tb/sv/frame_receiver_sum_checksum_core_tb.sv =====
// ----------------------------------------------------------------------------
// frame_receiver_sum_checksum_core_tb
// Self-checking bench for the length-prefixed frame receiver. Byte streams of
// well-formed frames, corrupted checksums, truncated frames and line noise go
// in under random idling on both channels; a tracker rebuilds the frame state
// for every accepted word and compares each result word field by field.
// ----------------------------------------------------------------------------
module frame_receiver_sum_checksum_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import frs_pkg::*;

   localparam int LONG_HOLD = 80;

   typedef enum logic [2:0] {
      HUNTING  = 3'd0,
      LEN_LOW  = 3'd1,
      LEN_HIGH = 3'd2,
      COMMAND  = 3'd3,
      PAYLOAD  = 3'd4,
      CHECKSUM = 3'd5
   } rx_phase_type;

   class frame_tracker_type;
      result_type   pending_results[$];
      rx_phase_type rx_phase;
      logic [15:0]  frame_len;
      logic [7:0]   frame_cmd;
      logic [7:0]   sum_acc;
      logic [15:0]  payload_count;
      int errors;
      int words_checked;
      int good_frames;
      int bad_frames;
      int payload_words;

      function new();
         rx_phase      = HUNTING;
         frame_len     = '0;
         frame_cmd     = '0;
         sum_acc       = '0;
         payload_count = '0;
         errors        = 0;
         words_checked = 0;
         good_frames   = 0;
         bad_frames    = 0;
         payload_words = 0;
      endfunction

      // advance the frame state by one accepted byte and queue its result word
      function void take_byte(logic [7:0] b);
         result_type  r;
         logic [7:0]  want_sum;
         r = '0;
         case (rx_phase)
            LEN_LOW: begin
               frame_len = {8'h00, b};
               sum_acc   = sum_acc + b;
               rx_phase  = LEN_HIGH;
            end
            LEN_HIGH: begin
               frame_len = {b, frame_len[7:0]};
               sum_acc   = sum_acc + b;
               rx_phase  = COMMAND;
            end
            COMMAND: begin
               frame_cmd = b;
               sum_acc   = sum_acc + b;
               if (frame_len != 16'd0) begin
                  payload_count = '0;
                  rx_phase      = PAYLOAD;
               end else begin
                  rx_phase = CHECKSUM;
               end
            end
            PAYLOAD: begin
               sum_acc       = sum_acc + b;
               r.data_valid  = 1'b1;
               r.data_byte   = b;
               r.data_index  = payload_count;
               payload_count = payload_count + 16'd1;
               if (payload_count >= frame_len)
                  rx_phase = CHECKSUM;
            end
            CHECKSUM: begin
               want_sum = ~sum_acc + 8'd1;
               r.status = (want_sum == b) ? STATUS_GOOD : STATUS_BAD_SUM;
               rx_phase = HUNTING;
            end
            default: begin
               // hunting clears the frame registers on every byte, sync included
               frame_len = '0;
               frame_cmd = '0;
               sum_acc   = '0;
               rx_phase  = (b == SYNC_BYTE) ? LEN_LOW : HUNTING;
            end
         endcase
         r.frame_command = frame_cmd;
         r.frame_length  = frame_len;
         pending_results.push_back(r);
      endfunction

      task report(string msg);
         if (errors < 50)
            $display("[%0t] MISMATCH %s", $realtime, msg);
         errors++;
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("%s: got 0x%0h, expected 0x%0h (word %0d)",
                             name, got, want, words_checked));
      endtask

      task check_word(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            report("result word arrived with nothing expected");
            return;
         end
         want = pending_results.pop_front();
         compare_field("status", 16'(got.status), 16'(want.status));
         compare_field("data_valid", 16'(got.data_valid), 16'(want.data_valid));
         compare_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
         compare_field("data_index", got.data_index, want.data_index);
         compare_field("frame_command", 16'(got.frame_command),
                       16'(want.frame_command));
         compare_field("frame_length", got.frame_length, want.frame_length);
         if (want.status == STATUS_GOOD)
            good_frames++;
         if (want.status == STATUS_BAD_SUM)
            bad_frames++;
         if (want.data_valid)
            payload_words++;
         words_checked++;
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic        rsp_data_valid;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_data_index;
   logic [7:0]  rsp_frame_command;
   logic [15:0] rsp_frame_length;

   frame_tracker_type tracker = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_ticket   = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int items_sent    = 0;

   frame_receiver_sum_checksum_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_data_valid    (rsp_data_valid),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_data_index    (rsp_data_index),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.take_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall)
            tracker.check_word({rsp_status, rsp_data_valid, rsp_data_byte,
                                rsp_data_index, rsp_frame_command,
                                rsp_frame_length});
      end
   end

   // result side: random stall, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == SYNC_BYTE);
      return b;
   endfunction

   // offer one word and hold it until taken; returns at the following falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid   = 1'b0;
         req_rx_byte = 8'($urandom_range(255));
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // fill < 0 gives random payload; cut >= 0 truncates after that many payload
   // words and flushes the rest of the frame with non-sync filler
   task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                             input bit bad_sum, input int cut, input int fill);
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      int         k;
      sum = len[7:0] + len[15:8] + cmd;
      send_byte(SYNC_BYTE);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      send_byte(cmd);
      for (i = 0; i < int'(len); i++) begin
         if (cut >= 0 && i == cut) begin
            for (k = 0; k < int'(len) - cut + 4; k++)
               send_byte(noise_byte());
            return;
         end
         if (fill >= 0)
            b = 8'(fill);
         else if ($urandom_range(15) == 0)
            b = SYNC_BYTE;
         else
            b = 8'($urandom_range(255));
         sum = sum + b;
         send_byte(b);
      end
      b = ~sum + 8'd1;
      if (bad_sum)
         b = b ^ 8'($urandom_range(1, 255));
      send_byte(b);
   endtask

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 85)
         return 16'($urandom_range(12));
      else if (r < 98)
         return 16'($urandom_range(13, 300));
      else
         return 16'($urandom_range(301, 1200));
   endfunction

   task automatic run_random(input int target);
      int          pick;
      int          k;
      logic [15:0] len;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            for (k = 0; k < $urandom_range(1, 4); k++)
               send_byte(noise_byte());
         end else if (pick < 78) begin
            send_frame(8'($urandom_range(255)), pick_length(), 1'b0, -1, -1);
         end else if (pick < 88) begin
            send_frame(8'($urandom_range(255)), pick_length(), 1'b1, -1, -1);
         end else begin
            len = 16'($urandom_range(1, 12));
            send_frame(8'($urandom_range(255)), len, 1'b0,
                       $urandom_range(0, int'(len) - 1), -1);
         end
      end
   endtask

   // stop offering and let every expected word come back
   task automatic drain();
      req_valid = 1'b0;
      while (tracker.pending_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 14;
      recv_idle_pct = 48;
      send_byte(8'h00);
      send_byte(8'hff);
      send_frame(8'hff, 16'd0, 1'b0, -1, -1);
      send_frame(8'h3a, 16'd2, 1'b1, -1, int'(SYNC_BYTE));
      send_frame(8'h00, 16'd1, 1'b0, -1, 255);
      send_frame(8'h5a, 16'd3, 1'b0, 1, -1);
      run_random(700);
      drain();

      send_idle_pct = 48;
      recv_idle_pct = 14;
      run_random(1400);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // hold the result side while the sender keeps streaming
      hold_ticket++;
      send_frame(8'hc3, 16'd60, 1'b0, -1, -1);
      run_random(2000);
      drain();
      repeat (8) @(negedge clock);

      if (tracker.pending_results.size() != 0)
         tracker.report("result words still expected at end of run");
      $display("Sent %0d words; checked %0d results with %0d payload bytes,",
               items_sent, tracker.words_checked, tracker.payload_words);
      $display("%0d good frames and %0d checksum errors, under stall and hold-off.",
               tracker.good_frames, tracker.bad_frames);
      if (tracker.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout: results stopped arriving");
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/frs_pkg.sv
rtl/frs_parse.sv
rtl/frame_receiver_sum_checksum_core.sv
tb/sv/frame_receiver_sum_checksum_core_tb.sv
